// File: hdl/flsk_pkg.sv
package flsk_pkg;

  localparam int unsigned NUM_HEIGHTS = 4;

  localparam logic [10:0] DIST_MUL    = 11'd1126;
  localparam int unsigned DIST_SHIFT  = 12;
  localparam logic [8:0]  DIST_MAX_Q4 = 9'd480;
  localparam logic [8:0]  SPIKE_Q4    = 9'd24;
  localparam logic [1:0]  FORCE_PHASE = 2'd2;
  localparam logic [1:0]  PHASE_WRAP  = 2'd3;

  localparam logic [2:0] CFG_HEIGHT0 = 3'd0;
  localparam logic [2:0] CFG_HEIGHT1 = 3'd1;
  localparam logic [2:0] CFG_HEIGHT2 = 3'd2;
  localparam logic [2:0] CFG_HEIGHT3 = 3'd3;
  localparam logic [2:0] CFG_DRIVE   = 3'd4;

  typedef logic [NUM_HEIGHTS-1:0][9:0] height_arr_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  floor;
    logic [15:0] echo_us;
  } in_item_t;

  typedef struct packed {
    logic       motor_on;
    logic       motor_up;
    logic [7:0] drive_pwm;
    logic [8:0] distance_q4;
    logic [1:0] current_floor;
    logic       arrived;
    logic       sample_rejected;
    logic       busy_res;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic       go;
    logic       floor_ok;
    logic [1:0] floor;
    logic [8:0] dist_q4;
    logic       rejected;
  } cmd_t;

endpackage

// File: hdl/floor_seek_motor_controller_unit.sv
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall   | in_item_t: req_type, floor, echo_us
// out_     | output    | out_valid/out_stall | out_item_t: motor/pwm/distance/flags
// cfg_     | input     | cfg_we              | cfg_index (3b), cfg_wdata (10b)
//
// One item per cycle sustained while out_stall stays low. Front converts and filters in
// the accept cycle; the item is written into the queue, then back pops it, updates motion
// state and registers the result. A 2-entry queue sits between them; in_stall rises only
// when it is full. Synchronous active-low reset; no clearing pass.
module floor_seek_motor_controller_unit #(
  parameter int FLOORS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  flsk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output flsk_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_wdata
);
  import flsk_pkg::*;

  height_arr_t heights_r, heights_nxt;
  logic [7:0]  drive_r, drive_nxt;
  logic        q_full, q_empty, q_push, q_pop;
  cmd_t        push_cmd, head_cmd;

  always_comb begin
    heights_nxt = heights_r;
    drive_nxt   = drive_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT0: heights_nxt[0] = cfg_wdata;
        CFG_HEIGHT1: heights_nxt[1] = cfg_wdata;
        CFG_HEIGHT2: heights_nxt[2] = cfg_wdata;
        CFG_HEIGHT3: heights_nxt[3] = cfg_wdata;
        CFG_DRIVE:   drive_nxt      = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heights_r <= '0;
      drive_r   <= 8'd255;
    end else begin
      heights_r <= heights_nxt;
      drive_r   <= drive_nxt;
    end
  end

  flsk_front #(
    .FLOORS(FLOORS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  flsk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  flsk_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .heights     (heights_r),
    .drive_level (drive_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: hdl/flsk_front.sv
module flsk_front #(
  parameter int FLOORS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  flsk_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output flsk_pkg::cmd_t     q_cmd
);
  import flsk_pkg::*;

  localparam logic [3:0] FLOORS_W = 4'(FLOORS);

  logic [8:0]  last_dist_r, last_dist_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [26:0] prod;
  logic [14:0] raw;
  logic [8:0]  dist_clip;
  logic [8:0]  diff;
  logic [1:0]  phase;
  logic        reject;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    prod      = {11'd0, in_data.echo_us} * {16'd0, DIST_MUL};
    raw       = prod[26:DIST_SHIFT];
    dist_clip = (raw > {6'd0, DIST_MAX_Q4}) ? 9'd0 : raw[8:0];
    diff      = (dist_clip > last_dist_r) ? (dist_clip - last_dist_r)
                                          : (last_dist_r - dist_clip);
    phase  = (phase_r == PHASE_WRAP) ? 2'd0 : phase_r;
    reject = (phase != FORCE_PHASE) && (diff > SPIKE_Q4);
    phase_nxt     = accept ? phase + 2'd1 : phase_r;
    last_dist_nxt = (accept && !reject) ? dist_clip : last_dist_r;
  end

  always_comb begin
    q_push         = accept;
    q_cmd.go       = in_data.req_type;
    q_cmd.floor    = in_data.floor;
    q_cmd.floor_ok = {2'b00, in_data.floor} < FLOORS_W;
    q_cmd.dist_q4  = reject ? last_dist_r : dist_clip;
    q_cmd.rejected = reject;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
      phase_r     <= '0;
    end else begin
      last_dist_r <= last_dist_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule

// File: hdl/flsk_queue.sv
module flsk_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  flsk_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output flsk_pkg::cmd_t head_cmd
);
  import flsk_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hdl/flsk_back.sv
module flsk_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  flsk_pkg::cmd_t        q_cmd,
  output logic                  q_pop,
  input  flsk_pkg::height_arr_t heights,
  input  logic [7:0]            drive_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output flsk_pkg::out_item_t   out_data
);
  import flsk_pkg::*;

  logic      moving_r, moving_nxt;
  logic      going_up_r, going_up_nxt;
  logic [1:0] target_r, target_nxt;
  logic [1:0] reached_r, reached_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic [9:0] dist_w;
  logic [9:0] h_target;
  logic      done;
  logic      arrived;
  logic      busy;

  assign q_pop     = ~q_empty & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dist_w       = {1'b0, q_cmd.dist_q4};
    h_target     = heights[target_r];
    done         = going_up_r ? (dist_w >= h_target) : (dist_w <= h_target);
    moving_nxt   = moving_r;
    going_up_nxt = going_up_r;
    target_nxt   = target_r;
    reached_nxt  = reached_r;
    arrived      = 1'b0;
    busy         = 1'b0;
    if (q_pop) begin
      if (moving_r) begin
        if (done) begin
          moving_nxt  = 1'b0;
          reached_nxt = target_r;
          arrived     = 1'b1;
        end
        busy = q_cmd.go;
      end else if (q_cmd.go && q_cmd.floor_ok) begin
        target_nxt   = q_cmd.floor;
        going_up_nxt = heights[q_cmd.floor] > dist_w;
        moving_nxt   = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt                 = out_data_r;
    out_valid_nxt                = out_valid_r & out_stall;
    if (q_pop) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.motor_on        = moving_nxt;
      out_data_nxt.motor_up        = moving_nxt & going_up_nxt;
      out_data_nxt.drive_pwm       = moving_nxt ? drive_level : 8'd0;
      out_data_nxt.distance_q4     = q_cmd.dist_q4;
      out_data_nxt.current_floor   = reached_nxt;
      out_data_nxt.arrived         = arrived;
      out_data_nxt.sample_rejected = q_cmd.rejected;
      out_data_nxt.busy_res        = busy;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r    <= 1'b0;
      going_up_r  <= 1'b0;
      target_r    <= 2'd0;
      reached_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      moving_r    <= moving_nxt;
      going_up_r  <= going_up_nxt;
      target_r    <= target_nxt;
      reached_r   <= reached_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
